>>> hw/rtl/mst_pkg.sv
// Shared types and constants for the multi-slot timer scheduler.
// Used by mst_slot_eval and multi_slot_timer_scheduler_core; no dependencies.
package mst_pkg;

  localparam int unsigned NUM_TIMERS_DEF = 16;

  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [TIME_W-1:0] PERIOD_STOPPED = '1;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_START   = 2'd1,
    OP_STOP    = 2'd2,
    OP_SET_TMO = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_EXPIRED = 2'd0,
    KIND_REPROG  = 2'd1,
    KIND_STOPPED = 2'd2,
    KIND_SAME    = 2'd3
  } kind_e;

  // Verdict on one slot during a tick walk.
  typedef struct packed {
    logic              expired;  // due time reached, slot restarts at now
    logic              active;   // active mark after this tick
    logic [TIME_W-1:0] rem;      // remaining time, meaningful when active
  } eval_t;

endpackage

>>> hw/rtl/mst_slot_eval.sv
// Per-slot expiry check and remaining-time computation for one tick.
// Depends on mst_pkg (eval_t, TIME_W, PERIOD_STOPPED).
module mst_slot_eval (
  input  logic                         act_i,
  input  logic                         auto_i,
  input  logic [mst_pkg::TIME_W-1:0]   tmo_i,
  input  logic [mst_pkg::TIME_W-1:0]   last_i,
  input  logic [mst_pkg::TIME_W-1:0]   now_i,
  output mst_pkg::eval_t               res_o
);
  import mst_pkg::*;

  logic [TIME_W:0]   due;
  logic [TIME_W+1:0] diff;
  logic              past;
  logic              hit;

  // One 33-bit add for the due time, one subtract against now; the sign of
  // the difference gives due < now and its zero test gives due == now.
  assign due  = {1'b0, last_i} + {1'b0, tmo_i};
  assign diff = {1'b0, due} - {2'b00, now_i};
  assign past = diff[TIME_W+1];
  assign hit  = act_i && (past || (diff == '0));

  always_comb begin
    res_o.expired = hit;
    res_o.active  = act_i && !(hit && !auto_i);
    if (hit || (last_i == now_i)) begin
      res_o.rem = tmo_i;
    end else if (past) begin
      res_o.rem = TIME_W'(1);
    end else if (diff[TIME_W]) begin
      res_o.rem = PERIOD_STOPPED;
    end else begin
      res_o.rem = diff[TIME_W-1:0];
    end
  end

endmodule

>>> hw/rtl/multi_slot_timer_scheduler_core.sv
// Top level of the multi-slot timer scheduler: slot tables, tick walk
// sequencer and output register. Depends on mst_pkg and mst_slot_eval.
//
// The block keeps NumTimers timer slots and the base clock period. Items
// arrive on the slave stream: tuser carries the operation (tick, start,
// stop, set timeout) and tdata the slot, timeout, mode and current time.
// Start, stop and set timeout pass through the operation state and give
// one result. A tick walks every slot in index order through one shared
// evaluator, one slot per cycle, reading the timeout and last-update
// tables through their single read port. A tick gives one result per
// expired slot in slot order, then a closing result with tlast set that
// tells whether the base period was reprogrammed, left unchanged or
// stopped. Every result of an item carries the base period in force after
// the whole item. The slave side takes no new transfer while an item is
// being worked on; it opens again as soon as the item's final result sits
// in the output register, so the next item overlaps the wait for the
// master side. The timeout and last-update tables need no clearing after
// reset since their contents only matter for slots that were started. The
// one configuration bit, when set, makes tick items vanish without
// results; the user must write it only while the block is idle, as the
// block itself does not enforce it.
module multi_slot_timer_scheduler_core #(
  parameter int unsigned NumTimers = mst_pkg::NUM_TIMERS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel: ticks_ignored.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_data_i,
  // Item input.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, lowest bit up: slot[3:0], timeout_ms[35:4], auto_mode[36],
  // now[68:37], zero fill[71:69].
  input  logic [mst_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: op[1:0].
  input  logic [1:0]                         s_axis_tuser,
  // Result output.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata, lowest bit up: expired_slot[3:0], base_period[35:4],
  // zero fill[39:36].
  output logic [mst_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // tuser: kind[1:0].
  output logic [1:0]                         m_axis_tuser,
  output logic                               m_axis_tlast
);
  import mst_pkg::*;

  localparam int unsigned IdxW = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int unsigned CntW = $clog2(NumTimers + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OP,
    ST_WALK,
    ST_FIN,
    ST_EMIT
  } state_e;

  state_e state_q;

  // Configuration.
  logic ign_q;

  // Captured item.
  op_e                op_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [TIME_W-1:0]  tmo_q;
  logic               auto_q;
  logic [TIME_W-1:0]  now_q;

  // Slot state in flops.
  logic [NumTimers-1:0] act_q;
  logic [NumTimers-1:0] auto_mode_q;
  logic [TIME_W-1:0]    period_q;

  // Slot tables and the list of expired slots of the current tick.
  logic [TIME_W-1:0] tmo_mem  [NumTimers];
  logic [TIME_W-1:0] last_mem [NumTimers];
  logic [IdxW-1:0]   exp_mem  [NumTimers];

  // Walk pipeline.
  logic [CntW-1:0]   cnt_q;
  logic              rd_vld_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic              act_rd_q;
  logic              auto_rd_q;
  logic [TIME_W-1:0] tmo_rd_q;
  logic [TIME_W-1:0] last_rd_q;
  logic              rem_vld_q;
  logic [TIME_W-1:0] rem_q;
  logic [TIME_W-1:0] min_q;
  logic              live_q;
  kind_e             close_kind_q;

  // Expired list pointers.
  logic [CntW-1:0] exp_cnt_q;
  logic [CntW-1:0] exp_rp_q;
  logic [CntW-1:0] exp_rp_d;
  logic [IdxW-1:0] exp_rdata_q;

  // Output register.
  logic              out_vld_q;
  kind_e             out_kind_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [TIME_W-1:0] out_period_q;
  logic              out_last_q;

  // Handshakes.
  logic in_fire;
  logic out_free;
  logic emit_exp;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign emit_exp      = (state_q == ST_EMIT) && out_free && (exp_rp_q != exp_cnt_q);

  // Single-slot operations.
  logic              slot_ok;
  logic [IdxW-1:0]   slot_idx;
  logic              any_act;
  logic [TIME_W-1:0] base_per;
  logic [TIME_W-1:0] prog_per;
  logic              lower;
  logic [TIME_W-1:0] op_period;
  logic              op_chg;

  assign slot_ok  = (TIME_W'(slot_q) < TIME_W'(NumTimers));
  assign slot_idx = IdxW'(slot_q);
  assign any_act  = |act_q;
  assign prog_per = (tmo_q == '0) ? TIME_W'(1) : tmo_q;

  always_comb begin
    base_per = period_q;
    lower    = 1'b0;
    case (op_q)
      OP_START: begin
        // With no slot running the period counts as stopped before the compare.
        base_per = any_act ? period_q : PERIOD_STOPPED;
        lower    = slot_ok && (tmo_q < base_per);
      end
      OP_SET_TMO: begin
        lower    = slot_ok && act_q[slot_idx] && (tmo_q < period_q);
      end
      default: begin
        lower    = 1'b0;
      end
    endcase
    if (lower) begin
      op_period = prog_per;
      op_chg    = (prog_per != base_per);
    end else if ((op_q == OP_START) && slot_ok) begin
      op_period = base_per;
      op_chg    = 1'b0;
    end else begin
      op_period = period_q;
      op_chg    = 1'b0;
    end
  end

  // Shared slot evaluator, fed by the registered table reads.
  eval_t ev;

  mst_slot_eval u_eval (
    .act_i  (act_rd_q),
    .auto_i (auto_rd_q),
    .tmo_i  (tmo_rd_q),
    .last_i (last_rd_q),
    .now_i  (now_q),
    .res_o  (ev)
  );

  logic            op_commit;
  logic            ev_fire;
  logic            ev_exp;
  logic [IdxW-1:0] rd_addr;

  assign op_commit = (state_q == ST_OP) && out_free && slot_ok;
  assign ev_fire   = (state_q == ST_WALK) && rd_vld_q;
  assign ev_exp    = ev_fire && ev.expired;
  assign rd_addr   = (cnt_q < CntW'(NumTimers)) ? cnt_q[IdxW-1:0] : '0;

  // Closing period after the walk.
  logic [TIME_W-1:0] fin_prog;
  assign fin_prog = (min_q == '0) ? TIME_W'(1) : min_q;

  always_comb begin
    exp_rp_d = exp_rp_q;
    if (in_fire) begin
      exp_rp_d = '0;
    end else if (emit_exp) begin
      exp_rp_d = exp_rp_q + CntW'(1);
    end
  end

  // Timeout table: written by start and set timeout.
  always_ff @(posedge clk_i) begin
    if (op_commit && ((op_q == OP_START) || (op_q == OP_SET_TMO))) begin
      tmo_mem[slot_idx] <= tmo_q;
    end
    tmo_rd_q <= tmo_mem[rd_addr];
  end

  // Last-update table: written by start and by expiry during a walk.
  always_ff @(posedge clk_i) begin
    if (ev_exp) begin
      last_mem[rd_idx_q] <= now_q;
    end else if (op_commit && (op_q == OP_START)) begin
      last_mem[slot_idx] <= now_q;
    end
    last_rd_q <= last_mem[rd_addr];
  end

  // Expired list, filled in slot order and drained in the same order.
  always_ff @(posedge clk_i) begin
    if (ev_exp) begin
      exp_mem[exp_cnt_q[IdxW-1:0]] <= rd_idx_q;
    end
    if (exp_rp_d < CntW'(NumTimers)) begin
      exp_rdata_q <= exp_mem[exp_rp_d[IdxW-1:0]];
    end
  end

  // Sequencer, slot flags and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ign_q        <= 1'b0;
      act_q        <= '0;
      auto_mode_q  <= '0;
      period_q     <= PERIOD_STOPPED;
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      rem_vld_q    <= 1'b0;
      live_q       <= 1'b0;
      exp_cnt_q    <= '0;
      exp_rp_q     <= '0;
      out_vld_q    <= 1'b0;
      close_kind_q <= KIND_SAME;
      op_q         <= OP_TICK;
    end else begin
      exp_rp_q <= exp_rp_d;

      if (cfg_valid_i && cfg_ready_o) begin
        ign_q <= cfg_data_i;
      end

      if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            op_q   <= op_e'(s_axis_tuser);
            slot_q <= s_axis_tdata[3:0];
            tmo_q  <= s_axis_tdata[35:4];
            auto_q <= s_axis_tdata[36];
            now_q  <= s_axis_tdata[68:37];
            if (op_e'(s_axis_tuser) != OP_TICK) begin
              state_q <= ST_OP;
            end else if (!ign_q) begin
              cnt_q     <= '0;
              rd_vld_q  <= 1'b0;
              rem_vld_q <= 1'b0;
              min_q     <= PERIOD_STOPPED;
              live_q    <= 1'b0;
              exp_cnt_q <= '0;
              state_q   <= ST_WALK;
            end
          end
        end

        ST_OP: begin
          if (out_free) begin
            if (slot_ok) begin
              case (op_q)
                OP_START: begin
                  act_q[slot_idx]       <= 1'b1;
                  auto_mode_q[slot_idx] <= auto_q;
                end
                OP_STOP: begin
                  act_q[slot_idx]       <= 1'b0;
                end
                default: begin
                end
              endcase
            end
            period_q     <= op_period;
            out_vld_q    <= 1'b1;
            out_kind_q   <= op_chg ? KIND_REPROG : KIND_SAME;
            out_slot_q   <= '0;
            out_period_q <= op_period;
            out_last_q   <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end

        ST_WALK: begin
          // Stage 1: issue the table read for the next slot.
          if (cnt_q < CntW'(NumTimers)) begin
            rd_vld_q  <= 1'b1;
            rd_idx_q  <= cnt_q[IdxW-1:0];
            act_rd_q  <= act_q[rd_addr];
            auto_rd_q <= auto_mode_q[rd_addr];
            cnt_q     <= cnt_q + CntW'(1);
          end else begin
            rd_vld_q  <= 1'b0;
          end
          // Stage 2: evaluate the slot read in the previous cycle.
          if (ev_fire) begin
            act_q[rd_idx_q] <= ev.active;
            if (ev.expired) begin
              exp_cnt_q <= exp_cnt_q + CntW'(1);
            end
          end
          rem_vld_q <= ev_fire && ev.active;
          rem_q     <= ev.rem;
          // Stage 3: running minimum over the live slots.
          if (rem_vld_q) begin
            live_q <= 1'b1;
            if (rem_q < min_q) begin
              min_q <= rem_q;
            end
          end
          if ((cnt_q == CntW'(NumTimers)) && !rd_vld_q && !rem_vld_q) begin
            state_q <= ST_FIN;
          end
        end

        ST_FIN: begin
          if (!live_q) begin
            period_q     <= PERIOD_STOPPED;
            close_kind_q <= KIND_STOPPED;
          end else begin
            period_q     <= fin_prog;
            close_kind_q <= (fin_prog != period_q) ? KIND_REPROG : KIND_SAME;
          end
          state_q <= ST_EMIT;
        end

        ST_EMIT: begin
          if (out_free) begin
            out_vld_q    <= 1'b1;
            out_period_q <= period_q;
            if (exp_rp_q != exp_cnt_q) begin
              out_kind_q <= KIND_EXPIRED;
              out_slot_q <= SLOT_W'(exp_rdata_q);
              out_last_q <= 1'b0;
            end else begin
              out_kind_q <= close_kind_q;
              out_slot_q <= '0;
              out_last_q <= 1'b1;
              state_q    <= ST_IDLE;
            end
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - SLOT_W - TIME_W){1'b0}}, out_period_q, out_slot_q};

  // The base period is never zero on a result.
  a_period_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_period_q != '0))
    else $error("result carries a zero base period");

  // An expiry report is never the final result of an item.
  a_expired_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_kind_q == KIND_EXPIRED)) |-> !out_last_q)
    else $error("expiry result flagged as last");

  // A stopped base clock is reported with the all-ones period.
  a_stopped_period : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_kind_q == KIND_STOPPED)) |-> (out_period_q == PERIOD_STOPPED))
    else $error("stopped base clock without all-ones period");

  // The expired list never holds more entries than there are slots, and the
  // drain pointer never runs past the fill count.
  a_exp_bounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_cnt_q <= CntW'(NumTimers)) && (exp_rp_q <= exp_cnt_q))
    else $error("expired list pointers out of range");

  // The walk only leaves for the closing step once its pipeline has drained.
  a_walk_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> (!rd_vld_q && !rem_vld_q && (cnt_q == CntW'(NumTimers))))
    else $error("walk finished with slots still in flight");

endmodule
